@@ src/kfi_pkg.sv @@
package kfi_pkg;

    localparam int MAX_KEYS  = 32;
    localparam int KEY_IDX_W = $clog2(MAX_KEYS);
    localparam int CNT_W     = 6;
    localparam int FRAC_W    = 16;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [4:0]           key_slot;
        logic [31:0]          key_time;
        logic signed [31:0]   key_x;
        logic signed [31:0]   key_y;
        logic signed [31:0]   key_z;
        logic [31:0]          query_time;
    } t_in;

    typedef struct packed {
        logic signed [31:0]   out_x;
        logic signed [31:0]   out_y;
        logic signed [31:0]   out_z;
        logic                 held_value;
    } t_out;

    typedef struct packed {
        logic [31:0] tm;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_key;

    // Search token that walks along the key cells.
    typedef struct packed {
        logic [31:0] qtime;
        logic        found;
        t_key        st;
        t_key        en;
    } t_tok;

    typedef enum logic [2:0] {
        LS_IDLE,
        LS_DIV,
        LS_MUL,
        LS_ADD,
        LS_OUT
    } t_lerp_st;

endpackage

@@ src/kfi_cell.sv @@
module kfi_cell
    import kfi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [KEY_IDX_W-1:0] i_idx,
    input  logic [CNT_W-1:0]     i_n_keys,
    input  logic                 i_wr_en,
    input  logic [KEY_IDX_W-1:0] i_wr_slot,
    input  t_key                 i_wr_key,
    input  logic                 i_tok_vld,
    input  t_tok                 i_tok,
    output logic                 o_tok_vld,
    output t_tok                 o_tok
);

    t_key r_key;
    logic r_tok_vld;
    t_tok r_tok;
    t_tok n_tok;
    logic w_active;

    assign w_active = ({{(CNT_W-KEY_IDX_W){1'b0}}, i_idx} < i_n_keys);

    // Until found, a later key past cell 0 is the end; other active cells are the start.
    always_comb begin
        n_tok = i_tok;
        if (w_active && !i_tok.found) begin
            if ((i_idx != '0) && (i_tok.qtime < r_key.tm)) begin
                n_tok.found = 1'b1;
                n_tok.en    = r_key;
            end else begin
                n_tok.st = r_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_slot == i_idx)) begin
            r_key <= i_wr_key;
        end
        r_tok <= n_tok;
        if (!i_rst_n) begin
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok_vld;
        end
    end

    assign o_tok_vld = r_tok_vld;
    assign o_tok     = r_tok;

endmodule

@@ src/kfi_lerp.sv @@
module kfi_lerp
    import kfi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_tok_vld,
    input  t_tok i_tok,
    input  logic i_out_stall,
    output logic o_out_valid,
    output t_out o_out_data,
    output logic o_done
);

    t_lerp_st            r_st, n_st;
    t_tok                r_tok;
    logic [31:0]         r_rem;
    logic [31:0]         r_dt;
    logic [FRAC_W-1:0]   r_q;
    logic [4:0]          r_cnt;
    logic [1:0]          r_comp;
    logic signed [49:0]  r_prod;
    t_out                r_res;
    logic                r_out_valid;
    t_out                r_out;

    logic [32:0]         w_rem2;
    logic [32:0]         w_diff;
    logic [31:0]         w_s, w_e;
    logic [32:0]         w_d;
    logic signed [49:0]  w_prod;
    logic                w_held;
    logic                w_load;

    always_comb begin
        case (r_comp)
            2'd0:    begin w_s = r_tok.st.x; w_e = r_tok.en.x; end
            2'd1:    begin w_s = r_tok.st.y; w_e = r_tok.en.y; end
            default: begin w_s = r_tok.st.z; w_e = r_tok.en.z; end
        endcase
    end

    assign w_d    = {w_e[31], w_e} - {w_s[31], w_s};
    assign w_prod = $signed(w_d) * $signed({1'b0, r_q});
    assign w_rem2 = {r_rem, 1'b0};
    assign w_diff = w_rem2 - {1'b0, r_dt};
    assign w_held = !i_tok.found || (i_tok.qtime < i_tok.st.tm)
                    || (i_tok.en.tm <= i_tok.st.tm);
    assign w_load = (r_st == LS_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_st = r_st;
        case (r_st)
            LS_IDLE: if (i_tok_vld) n_st = w_held ? LS_OUT : LS_DIV;
            LS_DIV:  if (r_cnt == 5'd1) n_st = LS_MUL;
            LS_MUL:  n_st = LS_ADD;
            LS_ADD:  n_st = (r_comp == 2'd2) ? LS_OUT : LS_MUL;
            LS_OUT:  if (w_load) n_st = LS_IDLE;
            default: n_st = LS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            LS_IDLE: begin
                r_tok  <= i_tok;
                r_rem  <= i_tok.qtime - i_tok.st.tm;
                r_dt   <= i_tok.en.tm - i_tok.st.tm;
                r_q    <= '0;
                r_cnt  <= 5'(FRAC_W);
                r_comp <= 2'd0;
                r_res  <= {i_tok.st.x, i_tok.st.y, i_tok.st.z, 1'b1};
            end
            LS_DIV: begin
                // One restoring step per cycle; the quotient stays below one.
                if (!w_diff[32]) begin
                    r_rem <= w_diff[31:0];
                    r_q   <= {r_q[FRAC_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem2[31:0];
                    r_q   <= {r_q[FRAC_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
            end
            LS_MUL: r_prod <= w_prod;
            LS_ADD: begin
                r_res.held_value <= 1'b0;
                case (r_comp)
                    2'd0:    r_res.out_x <= w_s + r_prod[47:16];
                    2'd1:    r_res.out_y <= w_s + r_prod[47:16];
                    default: r_res.out_z <= w_s + r_prod[47:16];
                endcase
                r_comp <= r_comp + 2'd1;
            end
            default: ;
        endcase
        if (w_load) begin
            r_out <= r_res;
        end
        if (!i_rst_n) begin
            r_st        <= LS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_done      = w_load;

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == LS_DIV) |-> (r_dt != '0)) else $error("zero divisor in division");
    a_tok_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok_vld |-> (r_st == LS_IDLE)) else $error("token arrived while busy");
    a_held_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == LS_IDLE && i_tok_vld && w_held) |=> (r_st == LS_OUT))
        else $error("held value did not go to output");

endmodule

@@ src/keyframe_linear_interpolator.sv @@
// Keyframe interpolator: write transactions store one key into a chain of
// MAX_KEYS key cells and finish at once; each query transaction returns one
// result. A query walks the cell chain (one cell per cycle), then a restoring
// divider forms the factor and one shared multiplier handles the three
// components in turn, each with a multiply step and an add step. The result
// then enters the output register and the next transaction can be accepted in
// the cycle after; a key value returned without interpolation skips the divider
// and the multiplier. A previous result still waiting under output stall delays
// the load. One query is in flight at a time; input stall is high until its
// result enters the output register.
module keyframe_linear_interpolator
    import kfi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  t_in              i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out             o_out_data,
    input  logic             i_out_stall
);

    logic [CNT_W-1:0] r_keys;
    logic [CNT_W-1:0] w_n_keys;
    logic             r_busy;
    logic             w_acc;
    logic             w_wr;
    logic             w_query;
    logic             w_done;
    t_key             w_wr_key;
    t_tok             w_tok0;

    logic [MAX_KEYS:0] w_vld;
    t_tok              w_tok [MAX_KEYS+1];

    assign w_acc    = i_in_valid && !r_busy;
    assign w_wr     = w_acc && (i_in_data.kind == KIND_WRITE);
    assign w_query  = w_acc && (i_in_data.kind == KIND_QUERY);
    assign w_n_keys = (r_keys == '0) ? CNT_W'(1)
                    : (r_keys > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : r_keys;
    assign w_wr_key = {i_in_data.key_time, i_in_data.key_x,
                       i_in_data.key_y, i_in_data.key_z};

    always_comb begin
        w_tok0       = '0;
        w_tok0.qtime = i_in_data.query_time;
    end

    assign w_vld[0] = w_query;
    assign w_tok[0] = w_tok0;

    genvar g;
    generate
        for (g = 0; g < MAX_KEYS; g++) begin : g_cell
            kfi_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_idx     (KEY_IDX_W'(g)),
                .i_n_keys  (w_n_keys),
                .i_wr_en   (w_wr),
                .i_wr_slot (i_in_data.key_slot[KEY_IDX_W-1:0]),
                .i_wr_key  (w_wr_key),
                .i_tok_vld (w_vld[g]),
                .i_tok     (w_tok[g]),
                .o_tok_vld (w_vld[g+1]),
                .o_tok     (w_tok[g+1])
            );
        end
    endgenerate

    kfi_lerp u_lerp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_vld   (w_vld[MAX_KEYS]),
        .i_tok       (w_tok[MAX_KEYS]),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_done      (w_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= CNT_W'(1);
            r_busy <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_keys <= i_cfg_wdata;
            end
            if (w_query) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_in_stall = r_busy;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld[MAX_KEYS:1])) else $error("more than one query in flight");
    a_tok_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_vld[MAX_KEYS:1]) |-> r_busy) else $error("token in chain while not busy");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_busy) else $error("result produced with no query pending");

endmodule
